### hw/rtl/dzcf_pkg.sv
package dzcf_pkg;

    // Field and working widths
    localparam int COORD_W     = 24;
    localparam int SIZE_W      = 23;
    localparam int WIDE_W      = 27;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    // Limits of a signed coordinate, carried at working width
    localparam logic signed [WIDE_W-1:0] WIDE_MAX = 27'sd8388607;
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -27'sd8388608;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_WIDTH      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_HEIGHT     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADZONE_WIDTH  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADZONE_HEIGHT = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_LEFT      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_BOTTOM    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_WIDTH     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_HEIGHT    = 4'd7;

    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] corner_x;
        logic signed [COORD_W-1:0] corner_y;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic                      moved;
        logic                      saturated;
    } out_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0]         view_width;
        logic [SIZE_W-1:0]         view_height;
        logic [SIZE_W-1:0]         deadzone_width;
        logic [SIZE_W-1:0]         deadzone_height;
        logic signed [COORD_W-1:0] level_left;
        logic signed [COORD_W-1:0] level_bottom;
        logic [SIZE_W-1:0]         level_width;
        logic [SIZE_W-1:0]         level_height;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic diff;
        logic check;
        logic div_init;
        logic div_step;
        logic div_end;
        logic mul;
        logic step;
        logic corner_a;
        logic corner_b;
        logic load_out;
        logic axis;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic follow;
        logic outside;
        logic big_x;
        logic big_y;
    } status_t;

    // Clip a working-width value to the signed coordinate range
    function automatic logic signed [COORD_W-1:0] clip_coord(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = (v > WIDE_MAX) ? WIDE_MAX : ((v < WIDE_MIN) ? WIDE_MIN : v);
        return c[COORD_W-1:0];
    endfunction

    function automatic logic clip_hit(input logic signed [WIDE_W-1:0] v);
        return (v > WIDE_MAX) || (v < WIDE_MIN);
    endfunction

endpackage

### hw/rtl/dzcf_cfg.sv
module dzcf_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dzcf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dzcf_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dzcf_pkg::cfg_t                     cfg
);

    dzcf_pkg::cfg_t cfg_reg;

    // Always able to take a write transaction
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the index and update one register; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dzcf_pkg::CFG_VIEW_WIDTH:
                    cfg_reg.view_width <= cfg_data[dzcf_pkg::SIZE_W-1:0];
                dzcf_pkg::CFG_VIEW_HEIGHT:
                    cfg_reg.view_height <= cfg_data[dzcf_pkg::SIZE_W-1:0];
                dzcf_pkg::CFG_DEADZONE_WIDTH:
                    cfg_reg.deadzone_width <= cfg_data[dzcf_pkg::SIZE_W-1:0];
                dzcf_pkg::CFG_DEADZONE_HEIGHT:
                    cfg_reg.deadzone_height <= cfg_data[dzcf_pkg::SIZE_W-1:0];
                dzcf_pkg::CFG_LEVEL_LEFT:
                    cfg_reg.level_left <= $signed(cfg_data[dzcf_pkg::COORD_W-1:0]);
                dzcf_pkg::CFG_LEVEL_BOTTOM:
                    cfg_reg.level_bottom <= $signed(cfg_data[dzcf_pkg::COORD_W-1:0]);
                dzcf_pkg::CFG_LEVEL_WIDTH:
                    cfg_reg.level_width <= cfg_data[dzcf_pkg::SIZE_W-1:0];
                dzcf_pkg::CFG_LEVEL_HEIGHT:
                    cfg_reg.level_height <= cfg_data[dzcf_pkg::SIZE_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

### hw/rtl/dzcf_dp.sv
module dzcf_dp #(
    parameter int LAMBDA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dzcf_pkg::cfg_t       cfg,
    input  dzcf_pkg::in_item_t   item,
    input  dzcf_pkg::cmd_t       cmd,
    output dzcf_pkg::status_t    status,
    output dzcf_pkg::out_item_t  result
);

    localparam int CW     = dzcf_pkg::COORD_W;
    localparam int WW     = dzcf_pkg::WIDE_W;
    localparam int SW     = dzcf_pkg::SIZE_W;
    localparam int DIV_W  = CW + 2;
    localparam int LAM_W  = LAMBDA_BITS + 1;
    localparam int PROD_W = CW + LAM_W;
    localparam logic [LAM_W-1:0] LAM_ONE = {1'b1, {LAMBDA_BITS{1'b0}}};

    // Architectural camera centre
    logic signed [CW-1:0] center_x_reg, center_y_reg;

    // Item and working registers
    logic                    mode_reg;
    logic signed [CW-1:0]    px_reg, py_reg;
    logic [CW-1:0]           mag_x_reg, mag_y_reg;
    logic                    neg_x_reg, neg_y_reg;
    logic [LAM_W-1:0]        lam_reg;
    logic [DIV_W-1:0]        rem_reg, dvs_reg;
    logic [LAMBDA_BITS-1:0]  quo_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    moved_reg, sat_reg;
    logic signed [WW-1:0]    c0_x_reg, c0_y_reg, fmv_x_reg, fmv_y_reg;
    logic signed [CW-1:0]    corner_x_reg, corner_y_reg;
    dzcf_pkg::out_item_t     result_reg;

    // Difference to target
    logic signed [CW:0] dx_w, dy_w, ndx_w, ndy_w;
    assign dx_w  = {px_reg[CW-1], px_reg} - {center_x_reg[CW-1], center_x_reg};
    assign dy_w  = {py_reg[CW-1], py_reg} - {center_y_reg[CW-1], center_y_reg};
    assign ndx_w = -dx_w;
    assign ndy_w = -dy_w;

    // Dead-zone test per axis: 2*|d| beyond the zone size
    logic big_x, big_y;
    assign big_x = {mag_x_reg, 1'b0} > {2'b00, cfg.deadzone_width};
    assign big_y = {mag_y_reg, 1'b0} > {2'b00, cfg.deadzone_height};

    assign status.follow  = mode_reg;
    assign status.big_x   = big_x;
    assign status.big_y   = big_y;
    assign status.outside = big_x | big_y;

    // Restoring divider step
    logic [DIV_W-1:0] rem_shift;
    logic             rem_ge;
    assign rem_shift = {rem_reg[DIV_W-2:0], 1'b0};
    assign rem_ge    = rem_shift >= dvs_reg;

    // Step magnitude from the shared multiplier
    logic [LAM_W-1:0] lam_comp;
    logic [CW-1:0]    mag_sel;
    logic [CW-1:0]    step_mag;
    assign lam_comp = LAM_ONE - lam_reg;
    assign mag_sel  = cmd.axis ? mag_y_reg : mag_x_reg;
    assign step_mag = prod_reg[LAMBDA_BITS +: CW];

    // New centre on the selected axis
    logic signed [WW-1:0] cen_sel_w, step_w, cen_next_w;
    logic                 neg_sel;
    assign cen_sel_w  = cmd.axis ? WW'(center_y_reg) : WW'(center_x_reg);
    assign step_w     = $signed({{(WW-CW){1'b0}}, step_mag});
    assign neg_sel    = cmd.axis ? neg_y_reg : neg_x_reg;
    assign cen_next_w = neg_sel ? (cen_sel_w - step_w) : (cen_sel_w + step_w);

    // Corner, first half: centre minus half view, and far edge minus view
    logic signed [WW-1:0] c0_x_next, c0_y_next, fmv_x_next, fmv_y_next;
    assign c0_x_next  = WW'(center_x_reg) - $signed({5'b0, cfg.view_width[SW-1:1]});
    assign c0_y_next  = WW'(center_y_reg) - $signed({5'b0, cfg.view_height[SW-1:1]});
    assign fmv_x_next = WW'(cfg.level_left) + $signed({4'b0, cfg.level_width})
                        - $signed({4'b0, cfg.view_width});
    assign fmv_y_next = WW'(cfg.level_bottom) + $signed({4'b0, cfg.level_height})
                        - $signed({4'b0, cfg.view_height});

    // Corner, second half: far clamp first, then near edge wins
    logic signed [WW-1:0] c1_x, c1_y, c2_x, c2_y, edge_x_w, edge_y_w;
    assign edge_x_w = WW'(cfg.level_left);
    assign edge_y_w = WW'(cfg.level_bottom);
    assign c1_x = (c0_x_reg > fmv_x_reg) ? fmv_x_reg : c0_x_reg;
    assign c1_y = (c0_y_reg > fmv_y_reg) ? fmv_y_reg : c0_y_reg;
    assign c2_x = (c1_x < edge_x_w) ? edge_x_w : c1_x;
    assign c2_y = (c1_y < edge_y_w) ? edge_y_w : c1_y;

    // Hold camera centre: load in set mode, advance in follow mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cmd.diff && !mode_reg)
        begin
            center_x_reg <= px_reg;
            center_y_reg <= py_reg;
        end
        else if (cmd.step)
        begin
            if (cmd.axis)
                center_y_reg <= dzcf_pkg::clip_coord(cen_next_w);
            else
                center_x_reg <= dzcf_pkg::clip_coord(cen_next_w);
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg  <= item.mode;
            px_reg    <= item.point_x;
            py_reg    <= item.point_y;
            moved_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end

        if (cmd.diff)
        begin
            neg_x_reg <= dx_w[CW];
            neg_y_reg <= dy_w[CW];
            mag_x_reg <= dx_w[CW] ? ndx_w[CW-1:0] : dx_w[CW-1:0];
            mag_y_reg <= dy_w[CW] ? ndy_w[CW-1:0] : dy_w[CW-1:0];
        end

        if (cmd.check)
        begin
            lam_reg   <= LAM_ONE;
            moved_reg <= status.outside;
        end

        // Start a division of zone size by twice the distance
        if (cmd.div_init)
        begin
            rem_reg <= cmd.axis ? DIV_W'(cfg.deadzone_height) : DIV_W'(cfg.deadzone_width);
            dvs_reg <= {1'b0, mag_sel, 1'b0};
            quo_reg <= '0;
        end

        // One quotient bit per cycle
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? (rem_shift - dvs_reg) : rem_shift;
            quo_reg <= {quo_reg[LAMBDA_BITS-2:0], rem_ge};
        end

        // Keep the smaller ratio
        if (cmd.div_end && ({1'b0, quo_reg} < lam_reg))
        begin
            lam_reg <= {1'b0, quo_reg};
        end

        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(mag_sel) * PROD_W'(lam_comp);
        end

        if (cmd.step && dzcf_pkg::clip_hit(cen_next_w))
        begin
            sat_reg <= 1'b1;
        end

        if (cmd.corner_a)
        begin
            c0_x_reg  <= c0_x_next;
            c0_y_reg  <= c0_y_next;
            fmv_x_reg <= fmv_x_next;
            fmv_y_reg <= fmv_y_next;
        end

        if (cmd.corner_b)
        begin
            corner_x_reg <= dzcf_pkg::clip_coord(c2_x);
            corner_y_reg <= dzcf_pkg::clip_coord(c2_y);
            if (dzcf_pkg::clip_hit(c2_x) || dzcf_pkg::clip_hit(c2_y))
                sat_reg <= 1'b1;
        end

        // Output register, held while the receiver stalls
        if (cmd.load_out)
        begin
            result_reg.corner_x  <= corner_x_reg;
            result_reg.corner_y  <= corner_y_reg;
            result_reg.center_x  <= center_x_reg;
            result_reg.center_y  <= center_y_reg;
            result_reg.moved     <= moved_reg;
            result_reg.saturated <= sat_reg;
        end
    end

    assign result = result_reg;

endmodule

### hw/rtl/dzcf_ctrl.sv
module dzcf_ctrl #(
    parameter int LAMBDA_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    output logic               result_valid,
    input  logic               result_stall,
    input  dzcf_pkg::status_t  status,
    output dzcf_pkg::cmd_t     cmd
);

    localparam int CNT_W = $clog2(LAMBDA_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_CHECK,
        S_AXIS,
        S_DIV_RUN,
        S_DIV_END,
        S_MUL,
        S_STEP,
        S_CORNER_A,
        S_CORNER_B,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic             axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             axis_big;

    assign axis_big = axis_reg ? status.big_y : status.big_x;

    // Sequence one item through the datapath
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = status.follow ? S_CHECK : S_CORNER_A;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                axis_next  = 1'b0;
                state_next = status.outside ? S_AXIS : S_CORNER_A;
            end
            S_AXIS:
            begin
                if (axis_big)
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV_RUN;
                end
                else if (!axis_reg)
                begin
                    axis_next = 1'b1;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(LAMBDA_BITS - 1))
                    state_next = S_DIV_END;
                else
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
            end
            S_DIV_END:
            begin
                cmd.div_end = 1'b1;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = S_AXIS;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = S_CORNER_A;
                end
            end
            S_CORNER_A:
            begin
                cmd.corner_a = 1'b1;
                state_next   = S_CORNER_B;
            end
            S_CORNER_B:
            begin
                cmd.corner_b = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output slot: fill on load, drain on a taken transaction
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    // A result never overwrites one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !result_stall))
        else $error("result overwritten while stalled");

    // An accepted item goes straight into the difference step
    a_accept_diff: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_DIFF))
        else $error("accepted item not started");

    // After handing over a result the block is ready for the next item
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (!item_stall && result_valid))
        else $error("block not ready after result");

    // Divider count stays within the quotient width
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_RUN) |-> (cnt_reg <= CNT_W'(LAMBDA_BITS - 1)))
        else $error("divider count out of range");

endmodule

### hw/rtl/deadzone_camera_follow_clamp.sv
// Camera dead-zone follow with level-bounds clamp.
//
// Channels: item (mode, point) in, result (corner, centre, flags) out, both with
// valid and stall; a transaction moves when valid is high and stall is low.
// Configuration is written through cfg_valid/cfg_ready with a register index;
// cfg_ready is always high and indexes past the last register are dropped.
//
// From item transaction to result valid, set mode runs the difference and
// corner steps only. Follow mode adds the dead-zone check, and each axis
// that exceeds the zone adds a run of the iterative divider, one quotient
// bit per cycle; both axes then take a multiply and a step. One item is in
// work at a time; the next is taken once the result is in the output
// register and the block is back in idle.
// The output register holds the result while the receiver stalls; if it is
// still full when a new result is ready, the block waits and keeps
// item_stall high.
// Reset clears the configuration, the camera centre and the output slot.
module deadzone_camera_follow_clamp #(
    parameter int LAMBDA_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  dzcf_pkg::in_item_t                item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output dzcf_pkg::out_item_t               result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dzcf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dzcf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    dzcf_pkg::cfg_t    cfg;
    dzcf_pkg::cmd_t    cmd;
    dzcf_pkg::status_t status;

    // Configuration registers
    dzcf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer
    dzcf_ctrl #(
        .LAMBDA_BITS (LAMBDA_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Arithmetic and state
    dzcf_dp #(
        .LAMBDA_BITS (LAMBDA_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule
